@@ rtl/core/midi_ind_pkg.sv @@
// ----------------------------------------------------------------------------
// midi_ind_pkg
// Shared types, codes and lookup tables of the indicator event decoder.
// ----------------------------------------------------------------------------
package midi_ind_pkg;

  localparam int unsigned LAMP_COUNT_DEF   = 50;
  localparam int unsigned RGB_CHANNELS_DEF = 4;

  localparam logic [3:0] MIN_LENGTH     = 4'd4;
  localparam logic [7:0] NOTE_CODE      = 8'h09;
  localparam logic [7:0] CTRL_CODE      = 8'h0b;
  localparam logic [3:0] PANEL_CHANNEL  = 4'd3;
  localparam logic [3:0] RGB_CHANNEL    = 4'd4;
  localparam logic [3:0] NOTE_CHANNELS  = 4'd3;
  localparam logic [7:0] NOTE_LIMIT     = 8'd27;
  localparam logic [7:0] VEL_OFF        = 8'd0;
  localparam logic [7:0] VEL_BLINK      = 8'd32;
  localparam logic [7:0] VEL_FLASH      = 8'd64;
  localparam logic [5:0] NO_LAMP        = 6'd50;
  localparam logic [7:0] DIGIT_ENTRIES  = 8'd11;
  localparam logic [7:0] COLOUR_ENTRIES = 8'd7;

  localparam logic [7:0] CC_BAR_LEFT     = 8'd0;
  localparam logic [7:0] CC_BAR_RIGHT    = 8'd1;
  localparam logic [7:0] CC_DIGITS_LEFT  = 8'd2;
  localparam logic [7:0] CC_DIGITS_RIGHT = 8'd3;
  localparam logic [7:0] CC_LEVEL_LEFT   = 8'd4;
  localparam logic [7:0] CC_LEVEL_RIGHT  = 8'd5;

  typedef enum logic [3:0] {
    KIND_NONE       = 4'd0,
    KIND_LAMP       = 4'd1,
    KIND_BAR_LEFT   = 4'd2,
    KIND_BAR_RIGHT  = 4'd3,
    KIND_DIG_LEFT   = 4'd4,
    KIND_DIG_RIGHT  = 4'd5,
    KIND_LVL_LEFT   = 4'd6,
    KIND_LVL_RIGHT  = 4'd7,
    KIND_RGB        = 4'd8
  } kind_e;

  typedef struct packed {
    logic [3:0] event_length;
    logic [7:0] code_byte;
    logic [7:0] status_byte;
    logic [7:0] number_byte;
    logic [7:0] value_byte;
  } in_t;

  typedef struct packed {
    logic [3:0] write_kind;
    logic [5:0] lamp_index;
    logic       steady_bit;
    logic       flash_bit;
    logic [7:0] first_value;
    logic [7:0] second_value;
    logic [7:0] third_value;
    logic [1:0] rgb_index;
    logic       range_error;
  } out_t;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] lamp_addr;
    logic       steady;
    logic       flash;
    logic [7:0] value;
    logic [3:0] digit_idx;
    logic [2:0] colour_idx;
    logic [3:0] rgb_num;
    logic       range_error;
  } dec_t;

  // key to lamp map, three rows of 27 notes, 50 marks an unmapped key
  localparam logic [5:0] LAMP_ROM [81] = '{
    6'd15, 6'd50, 6'd50, 6'd50, 6'd50, 6'd24, 6'd23, 6'd22, 6'd29, 6'd1,
    6'd32, 6'd31, 6'd30, 6'd8,  6'd7,  6'd50, 6'd50, 6'd50, 6'd50, 6'd14,
    6'd16, 6'd21, 6'd20, 6'd34, 6'd13, 6'd9,  6'd10,
    6'd44, 6'd50, 6'd50, 6'd50, 6'd50, 6'd28, 6'd19, 6'd18, 6'd17, 6'd1,
    6'd27, 6'd26, 6'd25, 6'd2,  6'd1,  6'd50, 6'd50, 6'd50, 6'd50, 6'd43,
    6'd47, 6'd46, 6'd45, 6'd42, 6'd48, 6'd49, 6'd41,
    6'd50, 6'd33, 6'd12, 6'd11, 6'd6,  6'd3,  6'd5,  6'd4,  6'd40, 6'd39,
    6'd38, 6'd35, 6'd36, 6'd37, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
    6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50
  };

  localparam logic [7:0] DIGIT_ROM [22] = '{
    8'd243, 8'd91,  8'd162, 8'd221, 8'd32,  8'd223, 8'd32,  8'd150,
    8'd32,  8'd91,  8'd0,   8'd130, 8'd0,   8'd91,  8'd0,   8'd150,
    8'd0,   8'd223, 8'd130, 8'd221, 8'd211, 8'd91
  };

  localparam logic [7:0] RED_ROM   [7] = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0};
  localparam logic [7:0] GREEN_ROM [7] = '{8'd0, 8'd0, 8'd50, 8'd120, 8'd150, 8'd200, 8'd255};
  localparam logic [7:0] BLUE_ROM  [7] = '{8'd0, 8'd255, 8'd100, 8'd0, 8'd0, 8'd200, 8'd0};

endpackage

@@ rtl/core/midi_indicator_decoder.sv @@
// ----------------------------------------------------------------------------
// midi_indicator_decoder
// Decodes four-byte USB-MIDI events into lamp, display and colour writes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  event   | in        | in_valid_i / in_stall_o | in_data_i  (midi_ind_pkg::in_t)
//  result  | out       | out_valid_o / out_stall_i | out_data_o (midi_ind_pkg::out_t)
//
//  one event per cycle sustained while out_stall_i is low
//  each event gives exactly one result
//  three register stages: input, decode, table lookup with output register
//  a stall holds each full stage only while the stage after it is full and held
//  reset clears all valid bits and the lamp, digit, bar and colour stores
// ----------------------------------------------------------------------------
module midi_indicator_decoder #(
  parameter int unsigned LAMP_COUNT   = midi_ind_pkg::LAMP_COUNT_DEF,
  parameter int unsigned RGB_CHANNELS = midi_ind_pkg::RGB_CHANNELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  midi_ind_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output midi_ind_pkg::out_t  out_data_o
);

  localparam int unsigned LAMP_IDX_W = (LAMP_COUNT > 1) ? $clog2(LAMP_COUNT) : 1;
  localparam int unsigned RGB_IDX_W  = (RGB_CHANNELS > 1) ? $clog2(RGB_CHANNELS) : 1;

  logic                s1_valid_q;
  midi_ind_pkg::in_t   s1_q;
  logic                s2_valid_q;
  midi_ind_pkg::dec_t  s2_q;
  midi_ind_pkg::dec_t  dec_d;
  logic                out_valid_q;
  midi_ind_pkg::out_t  out_q;
  midi_ind_pkg::out_t  res_d;

  logic out_en;
  logic s2_en;
  logic s1_en;
  logic commit;

  logic [LAMP_COUNT-1:0] steady_q, steady_d;
  logic [LAMP_COUNT-1:0] flash_q, flash_d;
  logic [7:0]            digit_q [4];
  logic [7:0]            digit_d [4];
  logic [7:0]            bar_q [4];
  logic [7:0]            bar_d [4];
  logic [23:0]           colour_q [RGB_CHANNELS];
  logic [23:0]           colour_d [RGB_CHANNELS];

  logic [5:0] lamp_n;
  logic       lamp_ok;
  logic [7:0] dig_first;
  logic [7:0] dig_second;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  assign out_en     = !out_valid_q || !out_stall_i;
  assign s2_en      = !s2_valid_q || out_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;
  assign commit     = out_en && s2_valid_q;

  // stage 1: input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  // stage 2: event decode
  always_comb begin
    dec_d      = '0;
    dec_d.kind = midi_ind_pkg::KIND_NONE;
    if (s1_q.event_length >= midi_ind_pkg::MIN_LENGTH) begin
      if (s1_q.code_byte == midi_ind_pkg::NOTE_CODE) begin
        if (s1_q.status_byte[3:0] < midi_ind_pkg::NOTE_CHANNELS &&
            s1_q.number_byte < midi_ind_pkg::NOTE_LIMIT) begin
          dec_d.kind      = midi_ind_pkg::KIND_LAMP;
          dec_d.lamp_addr = 7'(s1_q.status_byte[1:0]) * 7'd27 + 7'(s1_q.number_byte[4:0]);
          if (s1_q.value_byte == midi_ind_pkg::VEL_OFF) begin
            dec_d.steady = 1'b0;
            dec_d.flash  = 1'b0;
          end else if (s1_q.value_byte == midi_ind_pkg::VEL_BLINK) begin
            dec_d.steady = 1'b0;
            dec_d.flash  = 1'b1;
          end else if (s1_q.value_byte == midi_ind_pkg::VEL_FLASH) begin
            dec_d.steady = 1'b1;
            dec_d.flash  = 1'b1;
          end else begin
            dec_d.steady = 1'b1;
            dec_d.flash  = 1'b0;
          end
        end
      end else if (s1_q.code_byte == midi_ind_pkg::CTRL_CODE &&
                   s1_q.status_byte[3:0] == midi_ind_pkg::PANEL_CHANNEL) begin
        dec_d.value = s1_q.value_byte;
        unique case (s1_q.number_byte)
          midi_ind_pkg::CC_BAR_LEFT:     dec_d.kind = midi_ind_pkg::KIND_BAR_LEFT;
          midi_ind_pkg::CC_BAR_RIGHT:    dec_d.kind = midi_ind_pkg::KIND_BAR_RIGHT;
          midi_ind_pkg::CC_LEVEL_LEFT:   dec_d.kind = midi_ind_pkg::KIND_LVL_LEFT;
          midi_ind_pkg::CC_LEVEL_RIGHT:  dec_d.kind = midi_ind_pkg::KIND_LVL_RIGHT;
          midi_ind_pkg::CC_DIGITS_LEFT:  dec_d.kind = midi_ind_pkg::KIND_DIG_LEFT;
          midi_ind_pkg::CC_DIGITS_RIGHT: dec_d.kind = midi_ind_pkg::KIND_DIG_RIGHT;
          default:                       dec_d.kind = midi_ind_pkg::KIND_NONE;
        endcase
        dec_d.range_error = (s1_q.value_byte >= midi_ind_pkg::DIGIT_ENTRIES) &&
                            (dec_d.kind == midi_ind_pkg::KIND_DIG_LEFT ||
                             dec_d.kind == midi_ind_pkg::KIND_DIG_RIGHT);
        dec_d.digit_idx   = s1_q.value_byte[3:0];
      end else if (s1_q.code_byte == midi_ind_pkg::CTRL_CODE &&
                   s1_q.status_byte[3:0] == midi_ind_pkg::RGB_CHANNEL) begin
        dec_d.kind        = midi_ind_pkg::KIND_RGB;
        dec_d.range_error = (s1_q.number_byte >= 8'(RGB_CHANNELS)) ||
                            (s1_q.value_byte >= midi_ind_pkg::COLOUR_ENTRIES);
        dec_d.colour_idx  = s1_q.value_byte[2:0];
        dec_d.rgb_num     = s1_q.number_byte[3:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      s2_q <= dec_d;
    end
  end

  // stage 3: table lookup, result and store update
  assign lamp_n     = midi_ind_pkg::LAMP_ROM[s2_q.lamp_addr];
  assign lamp_ok    = (lamp_n < midi_ind_pkg::NO_LAMP) && ({1'b0, lamp_n} < 7'(LAMP_COUNT));
  assign dig_first  = midi_ind_pkg::DIGIT_ROM[{s2_q.digit_idx, 1'b0}];
  assign dig_second = midi_ind_pkg::DIGIT_ROM[{s2_q.digit_idx, 1'b1}];
  assign red        = midi_ind_pkg::RED_ROM[s2_q.colour_idx];
  assign green      = midi_ind_pkg::GREEN_ROM[s2_q.colour_idx];
  assign blue       = midi_ind_pkg::BLUE_ROM[s2_q.colour_idx];

  always_comb begin
    res_d      = '0;
    steady_d   = steady_q;
    flash_d    = flash_q;
    digit_d    = digit_q;
    bar_d      = bar_q;
    colour_d   = colour_q;
    case (s2_q.kind)
      midi_ind_pkg::KIND_LAMP: begin
        if (lamp_ok) begin
          res_d.write_kind = 4'(midi_ind_pkg::KIND_LAMP);
          res_d.lamp_index = lamp_n;
          res_d.steady_bit = s2_q.steady;
          res_d.flash_bit  = s2_q.flash;
          steady_d[lamp_n[LAMP_IDX_W-1:0]] = s2_q.steady;
          flash_d[lamp_n[LAMP_IDX_W-1:0]]  = s2_q.flash;
        end
      end
      midi_ind_pkg::KIND_BAR_LEFT, midi_ind_pkg::KIND_BAR_RIGHT,
      midi_ind_pkg::KIND_LVL_LEFT, midi_ind_pkg::KIND_LVL_RIGHT: begin
        res_d.write_kind  = 4'(s2_q.kind);
        res_d.first_value = s2_q.value;
        bar_d[{s2_q.kind[2], s2_q.kind[0]}] = s2_q.value;
      end
      midi_ind_pkg::KIND_DIG_LEFT, midi_ind_pkg::KIND_DIG_RIGHT: begin
        res_d.write_kind  = 4'(s2_q.kind);
        res_d.range_error = s2_q.range_error;
        if (!s2_q.range_error) begin
          res_d.first_value  = dig_first;
          res_d.second_value = dig_second;
          digit_d[{1'b0, s2_q.kind[0]}] = dig_first;
          digit_d[{1'b1, s2_q.kind[0]}] = dig_second;
        end
      end
      midi_ind_pkg::KIND_RGB: begin
        res_d.write_kind  = 4'(midi_ind_pkg::KIND_RGB);
        res_d.range_error = s2_q.range_error;
        if (!s2_q.range_error) begin
          res_d.first_value  = red;
          res_d.second_value = green;
          res_d.third_value  = blue;
          res_d.rgb_index    = s2_q.rgb_num[1:0];
          colour_d[s2_q.rgb_num[RGB_IDX_W-1:0]] = {red, green, blue};
        end
      end
      default: begin
        res_d.write_kind = 4'(midi_ind_pkg::KIND_NONE);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      steady_q    <= '0;
      flash_q     <= '0;
      digit_q     <= '{default: '0};
      bar_q       <= '{default: '0};
      colour_q    <= '{default: '0};
    end else begin
      if (out_en) begin
        out_valid_q <= s2_valid_q;
      end
      if (commit) begin
        steady_q <= steady_d;
        flash_q  <= flash_d;
        digit_q  <= digit_d;
        bar_q    <= bar_d;
        colour_q <= colour_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // pipeline never back-pressures while the output register is empty
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled with empty output register");

  // range errors only on digit and colour writes
  a_error_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.range_error) |->
      (out_q.write_kind == 4'(midi_ind_pkg::KIND_DIG_LEFT) ||
       out_q.write_kind == 4'(midi_ind_pkg::KIND_DIG_RIGHT) ||
       out_q.write_kind == 4'(midi_ind_pkg::KIND_RGB)))
    else $error("range error on wrong write kind");

  // lamp writes stay inside the lamp store
  a_lamp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.write_kind == 4'(midi_ind_pkg::KIND_LAMP)) |->
      ({1'b0, out_q.lamp_index} < 7'(LAMP_COUNT)))
    else $error("lamp index outside store");

  // a transfer that leaves stage 2 reaches the output register next cycle
  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && out_en) |=> out_valid_q)
    else $error("decoded item lost before output");
`endif

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indicator event decoder. A queue of events,
// directed corner cases first and then weighted random traffic, feeds a
// clocked driver with random idle gaps. A clocked monitor stalls at random,
// holds off once for a long stretch, and compares every result field by
// field against the write predicted for each transferred event.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import midi_ind_pkg::*;

  localparam int CYCLE_LIMIT    = 300000;
  localparam int EVENT_COUNT    = 850;
  localparam int HOLD_OFF_AT    = 200;
  localparam int HOLD_OFF_LEN   = 150;
  localparam int DRAIN_CYCLES   = 12;

  localparam logic [5:0] KEY_LAMP [81] = '{
    6'd15, 6'd50, 6'd50, 6'd50, 6'd50, 6'd24, 6'd23, 6'd22, 6'd29, 6'd1,
    6'd32, 6'd31, 6'd30, 6'd8,  6'd7,  6'd50, 6'd50, 6'd50, 6'd50, 6'd14,
    6'd16, 6'd21, 6'd20, 6'd34, 6'd13, 6'd9,  6'd10,
    6'd44, 6'd50, 6'd50, 6'd50, 6'd50, 6'd28, 6'd19, 6'd18, 6'd17, 6'd1,
    6'd27, 6'd26, 6'd25, 6'd2,  6'd1,  6'd50, 6'd50, 6'd50, 6'd50, 6'd43,
    6'd47, 6'd46, 6'd45, 6'd42, 6'd48, 6'd49, 6'd41,
    6'd50, 6'd33, 6'd12, 6'd11, 6'd6,  6'd3,  6'd5,  6'd4,  6'd40, 6'd39,
    6'd38, 6'd35, 6'd36, 6'd37, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
    6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50
  };

  localparam logic [7:0] SEGMENT_PAIRS [22] = '{
    8'd243, 8'd91,  8'd162, 8'd221, 8'd32,  8'd223, 8'd32,  8'd150,
    8'd32,  8'd91,  8'd0,   8'd130, 8'd0,   8'd91,  8'd0,   8'd150,
    8'd0,   8'd223, 8'd130, 8'd221, 8'd211, 8'd91
  };

  localparam logic [7:0] COLOUR_RED   [7] = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0};
  localparam logic [7:0] COLOUR_GREEN [7] = '{8'd0, 8'd0, 8'd50, 8'd120, 8'd150, 8'd200, 8'd255};
  localparam logic [7:0] COLOUR_BLUE  [7] = '{8'd0, 8'd255, 8'd100, 8'd0, 8'd0, 8'd200, 8'd0};

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  in_t  pending_events [$];
  out_t expected_writes [$];

  logic [LAMP_COUNT_DEF-1:0] lamp_steady;
  logic [LAMP_COUNT_DEF-1:0] lamp_flash;
  logic [7:0]                digit_segs [4];
  logic [7:0]                bar_vals [4];
  logic [23:0]               rgb_store [RGB_CHANNELS_DEF];

  int total_events;
  int sent_events;
  int received_writes;
  int error_count;
  int cycle_count;
  int send_idle_left;
  int recv_idle_left;
  int hold_off_left;
  int input_stall_cycles;
  bit send_calm;
  bit recv_calm;
  int lamp_writes;
  int panel_writes;
  int colour_writes;
  int flagged_writes;
  int ignored_events;

  midi_indicator_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic in_t make_event(logic [3:0] len, logic [7:0] code,
                                     logic [7:0] status, logic [7:0] num,
                                     logic [7:0] val);
    in_t ev;
    ev.event_length = len;
    ev.code_byte    = code;
    ev.status_byte  = status;
    ev.number_byte  = num;
    ev.value_byte   = val;
    return ev;
  endfunction

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  // write that one event causes, independent of the stores
  function automatic out_t decode_event(in_t ev);
    out_t       r;
    logic [3:0] ch;
    logic [7:0] num;
    logic [7:0] val;
    logic [5:0] lamp;
    int         idx;
    r   = '0;
    ch  = ev.status_byte[3:0];
    num = ev.number_byte;
    val = ev.value_byte;
    if (ev.event_length < MIN_LENGTH) return r;
    if (ev.code_byte == NOTE_CODE) begin
      if (ch < NOTE_CHANNELS && num < NOTE_LIMIT) begin
        idx  = int'(ch) * 27 + int'(num);
        lamp = KEY_LAMP[idx];
        if (lamp < NO_LAMP && lamp < LAMP_COUNT_DEF) begin
          r.write_kind = KIND_LAMP;
          r.lamp_index = lamp;
          r.steady_bit = !(val == VEL_OFF || val == VEL_BLINK);
          r.flash_bit  = (val == VEL_BLINK || val == VEL_FLASH);
        end
      end
    end else if (ev.code_byte == CTRL_CODE && ch == PANEL_CHANNEL) begin
      case (num)
        CC_BAR_LEFT:     r.write_kind = KIND_BAR_LEFT;
        CC_BAR_RIGHT:    r.write_kind = KIND_BAR_RIGHT;
        CC_LEVEL_LEFT:   r.write_kind = KIND_LVL_LEFT;
        CC_LEVEL_RIGHT:  r.write_kind = KIND_LVL_RIGHT;
        CC_DIGITS_LEFT:  r.write_kind = KIND_DIG_LEFT;
        CC_DIGITS_RIGHT: r.write_kind = KIND_DIG_RIGHT;
        default: ;
      endcase
      if (num == CC_DIGITS_LEFT || num == CC_DIGITS_RIGHT) begin
        if (val >= DIGIT_ENTRIES) begin
          r.range_error = 1'b1;
        end else begin
          r.first_value  = SEGMENT_PAIRS[int'(val) * 2];
          r.second_value = SEGMENT_PAIRS[int'(val) * 2 + 1];
        end
      end else if (r.write_kind != KIND_NONE) begin
        r.first_value = val;
      end
    end else if (ev.code_byte == CTRL_CODE && ch == RGB_CHANNEL) begin
      r.write_kind = KIND_RGB;
      if (num >= RGB_CHANNELS_DEF || val >= COLOUR_ENTRIES) begin
        r.range_error = 1'b1;
      end else begin
        r.first_value  = COLOUR_RED[val];
        r.second_value = COLOUR_GREEN[val];
        r.third_value  = COLOUR_BLUE[val];
        r.rgb_index    = num[1:0];
      end
    end
    return r;
  endfunction

  // mostly well-formed events with random content, some noise and short ones
  function automatic in_t random_event();
    in_t ev;
    int  sel;
    sel             = $urandom_range(0, 99);
    ev.event_length = 4'($urandom_range(4, 8));
    ev.code_byte    = 8'($urandom);
    ev.status_byte  = 8'($urandom);
    ev.number_byte  = 8'($urandom);
    ev.value_byte   = 8'($urandom);
    if (sel < 35) begin
      ev.code_byte          = NOTE_CODE;
      ev.status_byte[3:0]   = 4'($urandom_range(0, 2));
      if ($urandom_range(0, 9) != 0) ev.number_byte = 8'($urandom_range(0, 26));
      case ($urandom_range(0, 4))
        0: ev.value_byte = VEL_OFF;
        1: ev.value_byte = VEL_BLINK;
        2: ev.value_byte = VEL_FLASH;
        default: ;
      endcase
    end else if (sel < 60) begin
      ev.code_byte        = CTRL_CODE;
      ev.status_byte[3:0] = PANEL_CHANNEL;
      ev.number_byte      = 8'($urandom_range(0, 7));
      if ($urandom_range(0, 1) != 0) ev.value_byte = 8'($urandom_range(0, 12));
    end else if (sel < 80) begin
      ev.code_byte        = CTRL_CODE;
      ev.status_byte[3:0] = RGB_CHANNEL;
      ev.number_byte      = 8'($urandom_range(0, 5));
      if ($urandom_range(0, 5) != 0) ev.value_byte = 8'($urandom_range(0, 8));
    end else if (sel < 90) begin
      ev.event_length = 4'($urandom_range(0, 8));
    end else begin
      ev.event_length = 4'($urandom_range(0, 3));
      ev.code_byte    = ($urandom_range(0, 1) != 0) ? NOTE_CODE : CTRL_CODE;
    end
    return ev;
  endfunction

  task automatic check_field(string name, logic [7:0] exp, logic [7:0] act);
    if (act !== exp) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, exp, act);
      error_count++;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp;
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      in_data     <= '0;
      lamp_steady = '0;
      lamp_flash  = '0;
      for (int i = 0; i < 4; i++) begin
        digit_segs[i] = '0;
        bar_vals[i]   = '0;
      end
      for (int i = 0; i < RGB_CHANNELS_DEF; i++) rgb_store[i] = '0;
    end else begin
      if (in_valid && in_stall) input_stall_cycles++;
      if (!in_valid || !in_stall) begin
        if (in_valid) begin
          exp = decode_event(in_data);
          case (kind_e'(exp.write_kind))
            KIND_LAMP: begin
              lamp_steady[exp.lamp_index] = exp.steady_bit;
              lamp_flash[exp.lamp_index]  = exp.flash_bit;
            end
            KIND_BAR_LEFT:  bar_vals[0] = exp.first_value;
            KIND_BAR_RIGHT: bar_vals[1] = exp.first_value;
            KIND_LVL_LEFT:  bar_vals[2] = exp.first_value;
            KIND_LVL_RIGHT: bar_vals[3] = exp.first_value;
            KIND_DIG_LEFT: begin
              if (!exp.range_error) begin
                digit_segs[0] = exp.first_value;
                digit_segs[2] = exp.second_value;
              end
            end
            KIND_DIG_RIGHT: begin
              if (!exp.range_error) begin
                digit_segs[1] = exp.first_value;
                digit_segs[3] = exp.second_value;
              end
            end
            KIND_RGB: begin
              if (!exp.range_error)
                rgb_store[exp.rgb_index] = {exp.first_value, exp.second_value,
                                            exp.third_value};
            end
            default: ;
          endcase
          expected_writes.push_back(exp);
          sent_events++;
          if (sent_events % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
          send_idle_left = draw_wait(send_calm);
        end
        if (send_idle_left > 0) begin
          send_idle_left--;
          in_valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_events.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        received_writes++;
        if (expected_writes.size() == 0) begin
          $display("%0t ns: unexpected transfer, expected none actual kind %0d",
                   $time, out_data.write_kind);
          error_count++;
        end else begin
          exp = expected_writes.pop_front();
          check_field("write_kind",   8'(exp.write_kind),   8'(out_data.write_kind));
          check_field("lamp_index",   8'(exp.lamp_index),   8'(out_data.lamp_index));
          check_field("steady_bit",   8'(exp.steady_bit),   8'(out_data.steady_bit));
          check_field("flash_bit",    8'(exp.flash_bit),    8'(out_data.flash_bit));
          check_field("first_value",  exp.first_value,      out_data.first_value);
          check_field("second_value", exp.second_value,     out_data.second_value);
          check_field("third_value",  exp.third_value,      out_data.third_value);
          check_field("rgb_index",    8'(exp.rgb_index),    8'(out_data.rgb_index));
          check_field("range_error",  8'(exp.range_error),  8'(out_data.range_error));
          case (kind_e'(exp.write_kind))
            KIND_NONE: ignored_events++;
            KIND_LAMP: lamp_writes++;
            KIND_RGB:  colour_writes++;
            default:   panel_writes++;
          endcase
          if (exp.range_error) flagged_writes++;
        end
        if (received_writes % 50 == 0) recv_calm = ($urandom_range(0, 3) == 0);
        recv_idle_left = draw_wait(recv_calm);
        if (received_writes == HOLD_OFF_AT) hold_off_left = HOLD_OFF_LEN;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_stall <= 1'b1;
      end else if (recv_idle_left > 0) begin
        recv_idle_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d events sent",
               cycle_count, sent_events, total_events);
      $display("FAIL midi_indicator_decoder");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    // short events
    pending_events.push_back(make_event(4'd0, NOTE_CODE, 8'h00, 8'd0, 8'd127));
    pending_events.push_back(make_event(4'd3, NOTE_CODE, 8'h00, 8'd9, 8'd1));
    // lamp velocities and note edges
    pending_events.push_back(make_event(4'd4, NOTE_CODE, 8'h90, 8'd0, 8'd127));
    pending_events.push_back(make_event(4'd4, NOTE_CODE, 8'h90, 8'd0, VEL_BLINK));
    pending_events.push_back(make_event(4'd5, NOTE_CODE, 8'h90, 8'd0, VEL_FLASH));
    pending_events.push_back(make_event(4'd8, NOTE_CODE, 8'h90, 8'd0, VEL_OFF));
    pending_events.push_back(make_event(4'd4, NOTE_CODE, 8'hF1, 8'd26, 8'd255));
    pending_events.push_back(make_event(4'd4, NOTE_CODE, 8'h02, 8'd13, 8'd1));
    pending_events.push_back(make_event(4'd4, NOTE_CODE, 8'h02, 8'd26, VEL_FLASH));
    pending_events.push_back(make_event(4'd4, NOTE_CODE, 8'h00, NOTE_LIMIT, VEL_FLASH));
    pending_events.push_back(make_event(4'd4, NOTE_CODE, 8'hF3, 8'd0, VEL_FLASH));
    // panel controls
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'hB3, CC_BAR_LEFT, 8'd0));
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'hB3, CC_BAR_RIGHT, 8'd255));
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'h33, CC_LEVEL_LEFT, 8'd128));
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'hB3, CC_LEVEL_RIGHT, 8'd1));
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'hB3, CC_DIGITS_LEFT, 8'd0));
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'hB3, CC_DIGITS_RIGHT, 8'd10));
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'hB3, CC_DIGITS_LEFT,
                                        DIGIT_ENTRIES));
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'hB3, CC_DIGITS_RIGHT, 8'd255));
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'hB3, 8'd6, 8'd5));
    // colour controls
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'hB4, 8'd0, 8'd0));
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'hB4, 8'd3, 8'd6));
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'hB4, 8'd4, 8'd0));
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'hB4, 8'd1, COLOUR_ENTRIES));
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'hB4, 8'd255, 8'd255));
    // foreign codes and channels
    pending_events.push_back(make_event(4'd4, 8'hFF, 8'hF4, 8'd255, 8'd255));
    pending_events.push_back(make_event(4'd4, CTRL_CODE, 8'hB5, 8'd0, 8'd0));
    while (pending_events.size() < EVENT_COUNT) begin
      pending_events.push_back(random_event());
    end
    total_events = pending_events.size();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (sent_events < total_events || expected_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d events: %0d lamp, %0d panel, %0d colour writes, %0d ignored",
             sent_events, lamp_writes, panel_writes, colour_writes, ignored_events);
    $display("%0d out-of-range writes flagged, input held off for %0d cycles",
             flagged_writes, input_stall_cycles);
    if (error_count == 0) begin
      $display("PASS midi_indicator_decoder");
    end else begin
      $display("FAIL midi_indicator_decoder");
    end
    $finish;
  end

endmodule

@@ midi_indicator_decoder.f @@
rtl/core/midi_ind_pkg.sv
rtl/core/midi_indicator_decoder.sv
bench/tb.sv
